// ----- sv/ccst_pkg.sv -----
`timescale 1ns / 1ps

package ccst_pkg;

  // Field and datapath widths
  localparam int COORD_W    = 16;
  localparam int LANES      = 3;
  localparam int NPTS       = 4;
  localparam int IN_W       = LANES * NPTS * COORD_W;
  localparam int OUT_W      = LANES * COORD_W;
  localparam int COEF_W     = 20;
  localparam int BASIS_W    = 2;
  localparam int STEP_W     = 6;
  localparam int S2_W       = 2 * STEP_W;
  localparam int S3_W       = 3 * STEP_W;
  localparam int DEN_W      = S3_W + 3;
  localparam int P0_W       = COEF_W + S3_W + 1;
  localparam int P1_W       = COEF_W + S2_W + 1;
  localparam int P2_W       = COEF_W + STEP_W + 1;
  localparam int NUM_W      = 44;
  localparam int QUO_W      = COORD_W;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  // Basis codes (code 3 decodes as Bezier)
  localparam logic [BASIS_W-1:0] BASIS_BEZIER  = 2'd0;
  localparam logic [BASIS_W-1:0] BASIS_BSPLINE = 2'd1;
  localparam logic [BASIS_W-1:0] BASIS_CATROM  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASIS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS = 1'b1;

  localparam logic [STEP_W-1:0]  STEP_RESET = 6'd16;
  localparam logic [COORD_W-1:0] COORD_MIN  = 16'h8000;
  localparam logic [COORD_W-1:0] COORD_MAX  = 16'h7fff;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;

  // Monomial coefficients of one coordinate
  typedef struct packed {
    coef_t c3;
    coef_t c2;
    coef_t c1;
    coef_t c0;
  } coef4_t;

  // One queued segment: lane 0 is x, 1 is y, 2 is z
  typedef struct packed {
    coef4_t [LANES-1:0]  lane;
    logic [BASIS_W-1:0] basis;
  } seg_t;

  typedef struct packed {
    logic [BASIS_W-1:0] basis;
    logic [STEP_W-1:0]  steps;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } back_stat_t;

endpackage

// ----- sv/ccst_front.sv -----
`timescale 1ns / 1ps

module ccst_front (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [ccst_pkg::IN_W-1:0] in_tdata,
  input  ccst_pkg::cfg_t           cfg,
  input  logic                     q_full,
  output logic                     push,
  output ccst_pkg::seg_t           push_data
);

  logic [ccst_pkg::BASIS_W-1:0] basis_norm;

  // Basis matrix times control points, per coordinate
  function automatic ccst_pkg::coef4_t make_coefs(input logic [ccst_pkg::BASIS_W-1:0] basis,
                                                 input ccst_pkg::coord_t a,
                                                 input ccst_pkg::coord_t b,
                                                 input ccst_pkg::coord_t c,
                                                 input ccst_pkg::coord_t d);
    ccst_pkg::coef_t  ea;
    ccst_pkg::coef_t  eb;
    ccst_pkg::coef_t  ec;
    ccst_pkg::coef_t  ed;
    ccst_pkg::coef_t  bc;
    ccst_pkg::coef_t  mid;
    ccst_pkg::coef4_t k;
    ea  = ccst_pkg::COEF_W'(a);
    eb  = ccst_pkg::COEF_W'(b);
    ec  = ccst_pkg::COEF_W'(c);
    ed  = ccst_pkg::COEF_W'(d);
    bc  = eb - ec;
    mid = ea - (eb <<< 1) + ec;
    k.c3 = ed - ea + (bc <<< 1) + bc;
    unique case (basis)
      ccst_pkg::BASIS_BSPLINE: begin
        k.c0 = ea + (eb <<< 2) + ec;
        k.c1 = ((ec - ea) <<< 1) + (ec - ea);
        k.c2 = (mid <<< 1) + mid;
      end
      ccst_pkg::BASIS_CATROM: begin
        k.c0 = eb <<< 1;
        k.c1 = ec - ea;
        k.c2 = (ea <<< 1) - ((eb <<< 2) + eb) + (ec <<< 2) - ed;
      end
      default: begin
        k.c0 = ea;
        k.c1 = ((eb - ea) <<< 1) + (eb - ea);
        k.c2 = (mid <<< 1) + mid;
      end
    endcase
    return k;
  endfunction

  // Accept whenever the queue has room
  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  // Normalize the basis code so the back end sees only three kinds
  always_comb begin
    unique case (cfg.basis)
      ccst_pkg::BASIS_BSPLINE: basis_norm = ccst_pkg::BASIS_BSPLINE;
      ccst_pkg::BASIS_CATROM:  basis_norm = ccst_pkg::BASIS_CATROM;
      default:                 basis_norm = ccst_pkg::BASIS_BEZIER;
    endcase
  end

  assign push_data.basis = basis_norm;

  // Word field j sits at bits 16j up; point k coordinate l is field 3k + l
  for (genvar l = 0; l < ccst_pkg::LANES; l++) begin : g_lane
    assign push_data.lane[l] = make_coefs(
      cfg.basis,
      $signed(in_tdata[ccst_pkg::COORD_W*(0*ccst_pkg::LANES+l) +: ccst_pkg::COORD_W]),
      $signed(in_tdata[ccst_pkg::COORD_W*(1*ccst_pkg::LANES+l) +: ccst_pkg::COORD_W]),
      $signed(in_tdata[ccst_pkg::COORD_W*(2*ccst_pkg::LANES+l) +: ccst_pkg::COORD_W]),
      $signed(in_tdata[ccst_pkg::COORD_W*(3*ccst_pkg::LANES+l) +: ccst_pkg::COORD_W]));
  end

endmodule

// ----- sv/ccst_fifo.sv -----
`timescale 1ns / 1ps

module ccst_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccst_pkg::seg_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           valid,
  output ccst_pkg::seg_t head
);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  ccst_pkg::seg_t     mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid = (cnt_r != '0);
  assign head  = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- sv/ccst_back.sv -----
`timescale 1ns / 1ps

module ccst_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ccst_pkg::cfg_t            cfg,
  input  logic                      seg_valid,
  input  ccst_pkg::seg_t            seg,
  output ccst_pkg::back_stat_t      bk_st,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [ccst_pkg::OUT_W-1:0] out_tdata,
  output logic                      out_tlast,
  output logic                      out_tuser
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_CUBE, S_PROD, S_INIT, S_CHECK, S_DIV, S_EMIT
  } state_t;

  state_t                          state_r;
  logic [ccst_pkg::STEP_W-1:0]     s_eff;
  logic [ccst_pkg::S2_W-1:0]       s2_r;
  logic [ccst_pkg::S3_W-1:0]       s3_r;
  logic [ccst_pkg::DEN_W-1:0]      den_r;
  logic [ccst_pkg::DEN_W-1:0]      den_nxt;
  logic [ccst_pkg::NUM_W-1:0]      dv_r;
  logic [ccst_pkg::NUM_W-1:0]      lim_w;
  logic [ccst_pkg::NUM_W-1:0]      dv_init;
  logic [ccst_pkg::CNT_W-1:0]      cnt_r;
  logic [ccst_pkg::STEP_W-1:0]     idx_r;
  logic                            out_tvalid_r;
  logic                            out_tvalid_nxt;
  logic [ccst_pkg::OUT_W-1:0]      out_data_r;
  logic                            out_last_r;
  logic                            out_clip_r;
  logic                            emit_ok;
  logic                            last_pt;
  logic                            advance;
  logic [ccst_pkg::COORD_W-1:0]    res_w [ccst_pkg::LANES];
  logic [ccst_pkg::LANES-1:0]      clip_w;

  // Zero steps behaves as one
  assign s_eff   = (cfg.steps == '0) ? ccst_pkg::STEP_W'(1) : cfg.steps;
  assign emit_ok = !out_tvalid_r || out_tready;
  assign last_pt = (idx_r == s_eff);
  assign advance = (state_r == S_EMIT) && emit_ok && !last_pt;

  // Output word held until taken; a new one loads as the old one leaves
  assign out_tvalid_nxt = ((state_r == S_EMIT) && emit_ok) || (out_tvalid_r && !out_tready);

  assign bk_st.busy = (state_r != S_IDLE);
  assign bk_st.pop  = (state_r == S_INIT);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_clip_r;

  // Divisor D * s^3 for the basis
  always_comb begin
    unique case (seg.basis)
      ccst_pkg::BASIS_BSPLINE:
        den_nxt = (ccst_pkg::DEN_W'(s3_r) << 2) + (ccst_pkg::DEN_W'(s3_r) << 1);
      ccst_pkg::BASIS_CATROM:
        den_nxt = ccst_pkg::DEN_W'(s3_r) << 1;
      default:
        den_nxt = ccst_pkg::DEN_W'(s3_r);
    endcase
  end

  // Saturation bound 2^16 * 2den, and the top divisor step 2den << 15
  assign lim_w   = ccst_pkg::NUM_W'({den_r, {(ccst_pkg::QUO_W + 1){1'b0}}});
  assign dv_init = ccst_pkg::NUM_W'({den_r, {ccst_pkg::QUO_W{1'b0}}});

  // Sequencer: segment setup, then check / divide / emit per point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      idx_r        <= '0;
      cnt_r        <= '0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (seg_valid) begin
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          s2_r    <= s_eff * s_eff;
          state_r <= S_CUBE;
        end
        S_CUBE: begin
          s3_r    <= s2_r * s_eff;
          state_r <= S_PROD;
        end
        S_PROD: begin
          den_r   <= den_nxt;
          state_r <= S_INIT;
        end
        S_INIT: begin
          idx_r   <= '0;
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          dv_r    <= dv_init;
          cnt_r   <= '1;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dv_r <= dv_r >> 1;
          if (cnt_r == '0) begin
            state_r <= S_EMIT;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_data_r   <= {res_w[2], res_w[1], res_w[0]};
            out_last_r   <= last_pt;
            out_clip_r   <= |clip_w;
            if (last_pt) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_CHECK;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // One lane per coordinate: N(i) = 2num + den + 2^16 den by forward
  // differences, then a restoring divide by 2den for the offset quotient
  for (genvar l = 0; l < ccst_pkg::LANES; l++) begin : g_lane
    ccst_pkg::coef4_t                  cf;
    logic signed [ccst_pkg::P0_W-1:0]  p0_r;
    logic signed [ccst_pkg::P1_W-1:0]  p1_r;
    logic signed [ccst_pkg::P2_W-1:0]  p2_r;
    logic signed [ccst_pkg::NUM_W-1:0] n_r;
    logic signed [ccst_pkg::NUM_W-1:0] d1_r;
    logic signed [ccst_pkg::NUM_W-1:0] d2_r;
    logic signed [ccst_pkg::NUM_W-1:0] d3_r;
    logic signed [ccst_pkg::NUM_W-1:0] rem_r;
    logic signed [ccst_pkg::NUM_W-1:0] trial_w;
    logic signed [ccst_pkg::NUM_W-1:0] c3_w;
    logic signed [ccst_pkg::NUM_W-1:0] c3x12_w;
    logic signed [ccst_pkg::NUM_W-1:0] p1x2_w;
    logic signed [ccst_pkg::NUM_W-1:0] p2x2_w;
    logic signed [ccst_pkg::NUM_W-1:0] n0_w;
    logic signed [ccst_pkg::NUM_W-1:0] den_w;
    logic [ccst_pkg::QUO_W-1:0]        q_r;
    logic                              lo_r;
    logic                              hi_r;

    assign cf      = seg.lane[l];
    assign c3_w    = ccst_pkg::NUM_W'(cf.c3);
    assign c3x12_w = (c3_w <<< 3) + (c3_w <<< 2);
    assign p1x2_w  = ccst_pkg::NUM_W'(p1_r) <<< 1;
    assign p2x2_w  = ccst_pkg::NUM_W'(p2_r) <<< 1;
    assign den_w   = $signed(ccst_pkg::NUM_W'(den_r));
    assign n0_w    = (ccst_pkg::NUM_W'(p0_r) <<< 1) + den_w + (den_w <<< ccst_pkg::QUO_W);
    assign trial_w = rem_r - $signed(dv_r);

    always_ff @(posedge clk) begin
      case (state_r)
        S_PROD: begin
          p0_r <= cf.c0 * $signed({1'b0, s3_r});
          p1_r <= cf.c1 * $signed({1'b0, s2_r});
          p2_r <= cf.c2 * $signed({1'b0, s_eff});
        end
        S_INIT: begin
          n_r  <= n0_w;
          d1_r <= p1x2_w + p2x2_w + (c3_w <<< 1);
          d2_r <= (p2x2_w <<< 1) + c3x12_w;
          d3_r <= c3x12_w;
        end
        S_CHECK: begin
          rem_r <= n_r;
          lo_r  <= n_r[ccst_pkg::NUM_W-1];
          hi_r  <= (n_r >= $signed(lim_w));
          q_r   <= '0;
        end
        S_DIV: begin
          if (!trial_w[ccst_pkg::NUM_W-1]) begin
            rem_r <= trial_w;
            q_r   <= {q_r[ccst_pkg::QUO_W-2:0], 1'b1};
          end else begin
            q_r   <= {q_r[ccst_pkg::QUO_W-2:0], 1'b0};
          end
        end
        S_EMIT: begin
          if (advance) begin
            n_r  <= n_r + d1_r;
            d1_r <= d1_r + d2_r;
            d2_r <= d2_r + d3_r;
          end
        end
        default: ;
      endcase
    end

    // Quotient carries a +32768 offset: flip the top bit
    assign res_w[l]  = lo_r ? ccst_pkg::COORD_MIN :
                       hi_r ? ccst_pkg::COORD_MAX :
                       {~q_r[ccst_pkg::QUO_W-1], q_r[ccst_pkg::QUO_W-2:0]};
    assign clip_w[l] = lo_r | hi_r;
  end

endmodule

// ----- sv/cubic_curve_segment_tessellator_top.sv -----
`timescale 1ns / 1ps
// Per point: check, then a restoring divider (one quotient bit per cycle, 16 steps), then emit;
// each segment first passes the setup states (idle, square, cube, products, init).
// A two-entry segment queue lets the input side take words while points are produced.
// Reset (rst_n low, synchronous): queue and sequencer empty, basis Bezier, 16 steps.

module cubic_curve_segment_tessellator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: p0_x p0_y p0_z p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ccst_pkg::IN_W-1:0]       in_tdata,
  // out_tdata: out_x out_y out_z; out_tlast: last_point
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ccst_pkg::OUT_W-1:0]      out_tdata,
  output logic                            out_tlast,
  // out_tuser: clipped
  output logic                            out_tuser,
  input  logic                            cfg_we,
  input  logic [ccst_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [ccst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  ccst_pkg::cfg_t       cfg_r;
  ccst_pkg::seg_t       push_data;
  ccst_pkg::seg_t       seg;
  ccst_pkg::back_stat_t bk_st;
  logic                 push;
  logic                 q_full;
  logic                 seg_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis <= ccst_pkg::BASIS_BEZIER;
      cfg_r.steps <= ccst_pkg::STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ccst_pkg::REG_BASIS: cfg_r.basis <= cfg_wdata[ccst_pkg::BASIS_W-1:0];
        ccst_pkg::REG_STEPS: cfg_r.steps <= cfg_wdata[ccst_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  ccst_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg       (cfg_r),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ccst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (bk_st.pop),
    .full      (q_full),
    .valid     (seg_valid),
    .head      (seg)
  );

  ccst_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .seg_valid  (seg_valid),
    .seg        (seg),
    .bk_st      (bk_st),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Back end only releases a queue entry that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    bk_st.pop |-> seg_valid)
    else $error("segment queue popped while empty");

  // A new output word always comes from an active segment
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(bk_st.busy))
    else $error("output word raised while back end idle");

  // A word taken into an empty, idle block starts the back end once the queue holds it
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !seg_valid && !bk_st.busy) |=> ##1 bk_st.busy)
    else $error("back end did not start on a queued segment");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import ccst_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam longint COORD_LO = -32768;
  localparam longint COORD_HI = 32767;
  // code 3 is not assigned, the block decodes it as Bezier
  localparam logic [BASIS_W-1:0] BASIS_UNUSED = 2'd3;

  typedef coord_t seg_pts_t [4][3];   // [control point][lane x,y,z]

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     is_last;
    bit     clip;
  } curve_point_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // Expected curve points of every accepted segment, in order
  class tessellation_board;
    logic [BASIS_W-1:0] basis_sel = BASIS_BEZIER;
    logic [STEP_W-1:0]  interval_cnt = STEP_RESET;
    curve_point_t       expected_points[$];
    int                 errors = 0;

    function longint floor_quot(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      return q;
    endfunction

    // Monomial coefficients, then exact rational evaluation at t = i/s
    function void add_segment(seg_pts_t pts);
      longint k[3][4];
      longint a, b, c, d, s, dv, num, den, r, idx;
      coord_t val[3];
      curve_point_t pt;
      bit clip;
      int l;
      s = (interval_cnt == 0) ? 1 : longint'(interval_cnt);
      dv = (basis_sel == BASIS_BSPLINE) ? 6 : (basis_sel == BASIS_CATROM) ? 2 : 1;
      for (l = 0; l < 3; l++) begin
        a = pts[0][l];
        b = pts[1][l];
        c = pts[2][l];
        d = pts[3][l];
        k[l][3] = -a + 3 * b - 3 * c + d;
        if (basis_sel == BASIS_BSPLINE) begin
          k[l][0] = a + 4 * b + c;
          k[l][1] = -3 * a + 3 * c;
          k[l][2] = 3 * a - 6 * b + 3 * c;
        end else if (basis_sel == BASIS_CATROM) begin
          k[l][0] = 2 * b;
          k[l][1] = -a + c;
          k[l][2] = 2 * a - 5 * b + 4 * c - d;
        end else begin
          k[l][0] = a;
          k[l][1] = -3 * a + 3 * b;
          k[l][2] = 3 * a - 6 * b + 3 * c;
        end
      end
      den = dv * s * s * s;
      for (idx = 0; idx <= s; idx++) begin
        clip = 0;
        for (l = 0; l < 3; l++) begin
          num = k[l][0] * s * s * s + k[l][1] * idx * s * s
              + k[l][2] * idx * idx * s + k[l][3] * idx * idx * idx;
          // round half up, then saturate
          r = floor_quot(2 * num + den, 2 * den);
          if (r < COORD_LO) begin
            r = COORD_LO;
            clip = 1;
          end
          if (r > COORD_HI) begin
            r = COORD_HI;
            clip = 1;
          end
          val[l] = r[COORD_W-1:0];
        end
        pt.x = val[0];
        pt.y = val[1];
        pt.z = val[2];
        pt.is_last = (idx == s);
        pt.clip = clip;
        expected_points.insert(expected_points.size(), pt);
      end
    endfunction

    function void cmp_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("point field %s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void match_point(curve_point_t got);
      curve_point_t want;
      if (expected_points.size() == 0) begin
        $error("unexpected point x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        errors++;
        return;
      end
      want = expected_points.pop_front();
      cmp_field("out_x", want.x, got.x);
      cmp_field("out_y", want.y, got.y);
      cmp_field("out_z", want.z, got.z);
      cmp_field("last_point", want.is_last, got.is_last);
      cmp_field("clipped", want.clip, got.clip);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tessellation_board board;
  int src_idle_pct;
  int sink_stall_pct;
  longint cycle_cnt;

  cubic_curve_segment_tessellator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Result side: random stalls, check every accepted word
  initial out_tready = 0;
  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    curve_point_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.x = out_tdata[COORD_W-1:0];
      got.y = out_tdata[2*COORD_W-1:COORD_W];
      got.z = out_tdata[3*COORD_W-1:2*COORD_W];
      got.is_last = out_tlast;
      got.clip = out_tuser;
      board.match_point(got);
    end
  end

  function void set_idle(idle_mode_e mode);
    src_idle_pct = (mode == IDLE_SEND) ? 45 : (mode == IDLE_BOTH) ? 33 : 0;
    sink_stall_pct = (mode == IDLE_RECV) ? 45 : (mode == IDLE_BOTH) ? 33 : 0;
  endfunction

  // Entered and left at a falling edge
  task write_reg(logic [CFG_IDX_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    cfg_addr = addr;
    cfg_wdata = data;
    cfg_we = 1;
    @(posedge clk);
    if (addr == REG_BASIS) board.basis_sel = data[BASIS_W-1:0];
    else board.interval_cnt = data[STEP_W-1:0];
    @(negedge clk);
    cfg_we = 0;
  endtask

  // Registers change only once every expected point is out
  task configure(logic [BASIS_W-1:0] basis, logic [STEP_W-1:0] steps);
    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    write_reg(REG_BASIS, CFG_DATA_W'(basis));
    write_reg(REG_STEPS, steps);
  endtask

  task send_segment(seg_pts_t pts);
    int p, l;
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid = 0;
      @(negedge clk);
    end
    for (p = 0; p < 4; p++)
      for (l = 0; l < 3; l++)
        in_tdata[(p * 3 + l) * COORD_W +: COORD_W] = pts[p][l];
    in_tvalid = 1;
    do @(posedge clk); while (!in_tready);
    board.add_segment(pts);
    @(negedge clk);
  endtask

  // x takes v0..v3, y the reverse order, z the bitwise inverse
  task send_pattern(coord_t v0, coord_t v1, coord_t v2, coord_t v3);
    seg_pts_t pts;
    coord_t v[4];
    int p;
    v = '{v0, v1, v2, v3};
    for (p = 0; p < 4; p++) begin
      pts[p][0] = v[p];
      pts[p][1] = v[3 - p];
      pts[p][2] = ~v[p];
    end
    send_segment(pts);
    in_tvalid = 0;
  endtask

  function coord_t rand_coord();
    case ($urandom_range(9))
      0: return coord_t'(COORD_MAX);
      1: return coord_t'(COORD_MIN);
      2, 3: return coord_t'($urandom_range(64)) - 16'sd32;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task run_random(logic [BASIS_W-1:0] basis, logic [STEP_W-1:0] steps, int n,
                  idle_mode_e mode);
    seg_pts_t pts;
    int p, l;
    configure(basis, steps);
    set_idle(mode);
    repeat (n) begin
      for (p = 0; p < 4; p++)
        for (l = 0; l < 3; l++)
          pts[p][l] = rand_coord();
      send_segment(pts);
    end
    in_tvalid = 0;
  endtask

  initial begin
    coord_t cmax, cmin;
    cmax = coord_t'(COORD_MAX);
    cmin = coord_t'(COORD_MIN);
    board = new();
    set_idle(IDLE_NONE);
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    cfg_we = 0;
    cfg_addr = REG_BASIS;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: reset settings (Bezier, 16 steps)
    send_pattern(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pattern(cmax, cmax, cmax, cmax);
    send_pattern(cmin, cmax, cmin, cmax);
    send_pattern(16'sd1, -16'sd1, 16'sd16, -16'sd16);

    // B-spline with a single interval
    configure(BASIS_BSPLINE, 6'd1);
    send_pattern(cmax, cmax, cmax, cmax);
    send_pattern(cmin, cmin, cmin, cmin);
    send_pattern(cmin, cmax, cmax, cmin);

    // Catmull-Rom, zero step count acts as one
    configure(BASIS_CATROM, 6'd0);
    send_pattern(cmin, cmax, cmax, cmin);
    send_pattern(cmax, cmin, cmin, cmax);

    // Catmull-Rom overshoot drives saturation
    configure(BASIS_CATROM, 6'd4);
    send_pattern(cmin, cmax, cmax, cmin);
    send_pattern(cmax, cmin, cmin, cmax);
    send_pattern(cmax, cmin, cmax, cmin);

    // Unused basis code at the largest step count
    configure(BASIS_UNUSED, 6'd63);
    send_pattern(cmin, cmax, cmin, cmax);
    send_pattern(cmax, 16'sd0, cmin, 16'sd1);

    // Random segments
    run_random(BASIS_BEZIER, 6'd3, 40, IDLE_NONE);
    run_random(BASIS_BSPLINE, 6'd7, 40, IDLE_SEND);
    run_random(BASIS_CATROM, 6'd5, 40, IDLE_RECV);
    run_random(BASIS_UNUSED, 6'd2, 30, IDLE_BOTH);
    run_random(BASIS_CATROM, 6'd16, 30, IDLE_BOTH);
    run_random(BASIS_BSPLINE, 6'd0, 30, IDLE_NONE);
    run_random(BASIS_BEZIER, 6'd12, 30, IDLE_SEND);
    run_random(BASIS_CATROM, 6'd63, 4, IDLE_RECV);
    run_random(BASIS_W'($urandom_range(3)), STEP_W'($urandom_range(1, 8)), 20, IDLE_BOTH);

    // Drain, then allow a little extra time for stray words
    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0 && board.expected_points.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- cubic_curve_segment_tessellator_top.f -----
sv/ccst_pkg.sv
sv/ccst_front.sv
sv/ccst_fifo.sv
sv/ccst_back.sv
sv/cubic_curve_segment_tessellator_top.sv
verif/testbench.sv
